### hw/rtl/mh64a_pkg.sv
// constants and types shared by the murmur 64a hash block
// no dependencies
package mh64a_pkg;

  localparam logic [63:0] MH_MUL       = 64'hc6a4a7935bd1e995;
  localparam int unsigned MH_SHIFT     = 47;
  localparam logic [31:0] MH_SEED_RST  = 32'd7079;
  localparam logic [3:0]  MH_FULL_BYTES = 4'd8;
  localparam logic [3:0]  MH_NO_BYTES   = 4'd0;

  typedef logic [63:0] mh_word_t;

endpackage

### hw/rtl/mh64a_in_if.sv
// input channel of the murmur 64a hash block: one key word per transaction
// no dependencies
interface mh64a_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_word;
  logic [3:0]  valid_bytes;
  logic [31:0] message_length;
  logic        first_item;
  logic        last_item;

  modport source (output valid, output data_word, output valid_bytes,
                  output message_length, output first_item, output last_item,
                  input ready);
  modport sink (input valid, input data_word, input valid_bytes,
                input message_length, input first_item, input last_item,
                output ready);
endinterface

### hw/rtl/mh64a_out_if.sv
// result channel of the murmur 64a hash block: one finished hash per transaction
// no dependencies
interface mh64a_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] hash_value;

  modport source (output valid, output hash_value, input ready);
  modport sink (input valid, input hash_value, output ready);
endinterface

### hw/rtl/mh64a_mul.sv
// 64-bit wrapping multiply by the mix constant on one shared 32x32 multiplier
// three partial products computed in turn; depends on mh64a_pkg
module mh64a_mul (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  mh64a_pkg::mh_word_t a,
  output logic                done,
  output mh64a_pkg::mh_word_t prod
);
  import mh64a_pkg::*;

  typedef enum logic [1:0] {ST_LL, ST_LH, ST_HL} step_t;

  step_t       step_r;
  logic        busy_r;
  logic        done_r;
  mh_word_t    a_r;
  mh_word_t    acc_r;
  logic [31:0] x;
  logic [31:0] y;
  logic [63:0] p;

  always_comb begin
    unique case (step_r)
      ST_LL: begin
        x = a_r[31:0];
        y = MH_MUL[31:0];
      end
      ST_LH: begin
        x = a_r[31:0];
        y = MH_MUL[63:32];
      end
      ST_HL: begin
        x = a_r[63:32];
        y = MH_MUL[31:0];
      end
      default: begin
        x = a_r[31:0];
        y = MH_MUL[31:0];
      end
    endcase
    p = 64'(x) * 64'(y);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= ST_LL;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        a_r    <= a;
        busy_r <= 1'b1;
        step_r <= ST_LL;
      end else if (busy_r) begin
        unique case (step_r)
          ST_LL: begin
            acc_r  <= p;
            step_r <= ST_LH;
          end
          ST_LH: begin
            acc_r[63:32] <= acc_r[63:32] + p[31:0];
            step_r       <= ST_HL;
          end
          ST_HL: begin
            acc_r[63:32] <= acc_r[63:32] + p[31:0];
            busy_r       <= 1'b0;
            done_r       <= 1'b1;
            step_r       <= ST_LL;
          end
          default: step_r <= ST_LL;
        endcase
      end
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

### hw/rtl/murmur_hash_64a.sv
// murmur 64a key hasher: sequencer around one shared multiply unit
// depends on mh64a_pkg, mh64a_in_if, mh64a_out_if, mh64a_mul
//
// A key enters as a stream of 64-bit little-endian words on in_if, one word
// per transaction; first_item starts a new hash from the seed and
// message_length, last_item closes the key. valid_bytes of 8 mixes a full
// word, 1 to 7 xors a tail, 0 adds nothing (values above 8 count as 8).
// The finished hash leaves on out_if as one transaction per last word.
// The seed is written through cfg_wr_en / cfg_wr_data; the user must write it
// only while the block idles, which the block itself does not enforce. All
// multiplies run on one 32x32 multiplier, three partial products per 64-bit
// multiply plus a hand-over step. A word is accepted; if first, the seed setup
// multiply runs; the word is dispatched and mixed, with three multiplies for a
// full word or one for a tail (none for 0 bytes); a decide step follows, and if
// last, the finalize multiply and the load of the output register, plus any
// wait for that register. in_if.ready is high only while the sequencer idles.
// The result sits in an output register; the next word is taken while it
// waits, and a following result waits for out_if.ready.
// Reset sets the seed to 7079, clears the running hash and empties the output.
module murmur_hash_64a (
  input  logic              clk,
  input  logic              rst_n,
  mh64a_in_if.sink          in_if,
  mh64a_out_if.source       out_if,
  input  logic              cfg_wr_en,
  input  logic [31:0]       cfg_wr_data
);
  import mh64a_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_INIT, S_BODY, S_K1, S_K2, S_H, S_CHK, S_FIN, S_OUT
  } state_t;

  state_t      state_r;
  logic [31:0] seed_r;
  mh_word_t    h_r;
  mh_word_t    word_r;
  mh_word_t    fin_r;
  mh_word_t    out_hash_r;
  logic        out_valid_r;
  logic [3:0]  nb_r;
  logic        last_r;

  logic        mul_start;
  mh_word_t    mul_a;
  logic        mul_done;
  mh_word_t    mul_p;
  mh_word_t    keep;
  mh_word_t    p_mix;
  mh_word_t    h_mix;
  logic [3:0]  nb_sat;
  logic        out_free;

  mh64a_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .done  (mul_done),
    .prod  (mul_p)
  );

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      keep[i*8 +: 8] = (4'(i) < nb_r) ? 8'hff : 8'h00;
    end
    p_mix  = mul_p ^ (mul_p >> MH_SHIFT);
    h_mix  = h_r ^ (h_r >> MH_SHIFT);
    nb_sat = (in_if.valid_bytes > MH_FULL_BYTES) ? MH_FULL_BYTES : in_if.valid_bytes;
    out_free = !out_valid_r || out_if.ready;
  end

  always_comb begin
    mul_start = 1'b0;
    mul_a     = word_r;
    unique case (state_r)
      S_IDLE: begin
        mul_start = in_if.valid && in_if.first_item;
        mul_a     = {32'd0, in_if.message_length};
      end
      S_BODY: begin
        mul_start = (nb_r != MH_NO_BYTES);
        mul_a     = (nb_r == MH_FULL_BYTES) ? word_r : (h_r ^ (word_r & keep));
      end
      S_K1: begin
        mul_start = mul_done;
        mul_a     = p_mix;
      end
      S_K2: begin
        mul_start = mul_done;
        mul_a     = h_r ^ mul_p;
      end
      S_CHK: begin
        mul_start = last_r;
        mul_a     = h_mix;
      end
      default: begin
        mul_start = 1'b0;
        mul_a     = word_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      seed_r      <= MH_SEED_RST;
      h_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        seed_r <= cfg_wr_data;
      end
      if (out_valid_r && out_if.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_if.valid) begin
            word_r  <= in_if.data_word;
            nb_r    <= nb_sat;
            last_r  <= in_if.last_item;
            state_r <= in_if.first_item ? S_INIT : S_BODY;
          end
        end
        S_INIT: begin
          if (mul_done) begin
            h_r     <= {32'd0, seed_r} ^ mul_p;
            state_r <= S_BODY;
          end
        end
        S_BODY: begin
          priority if (nb_r == MH_FULL_BYTES) begin
            state_r <= S_K1;
          end else if (nb_r != MH_NO_BYTES) begin
            state_r <= S_H;
          end else begin
            state_r <= S_CHK;
          end
        end
        S_K1: begin
          if (mul_done) begin
            state_r <= S_K2;
          end
        end
        S_K2: begin
          if (mul_done) begin
            state_r <= S_H;
          end
        end
        S_H: begin
          if (mul_done) begin
            h_r     <= mul_p;
            state_r <= S_CHK;
          end
        end
        S_CHK: begin
          state_r <= last_r ? S_FIN : S_IDLE;
        end
        S_FIN: begin
          if (mul_done) begin
            fin_r   <= p_mix;
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_hash_r  <= fin_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_if.ready       = (state_r == S_IDLE);
  assign out_if.valid      = out_valid_r;
  assign out_if.hash_value = out_hash_r;

endmodule

### dv/tb_murmur_hash_64a.sv
`timescale 1ns / 1ps
// self-checking bench for murmur_hash_64a: keys go in as word streams, hashes come out
// depends on mh64a_pkg, mh64a_in_if, mh64a_out_if and the murmur_hash_64a rtl
// an inline model of the hash predicts every result and each output transaction is compared
module tb_murmur_hash_64a;
  import mh64a_pkg::*;

  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_WORDS = 1000;
  localparam longint LIMIT_NS = 10_000_000;

  typedef struct {
    logic [63:0] data;
    logic [3:0]  nbytes;
    logic [31:0] len;
    logic        first;
    logic        last;
  } key_word_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [31:0] cfg_wr_data;

  mh64a_in_if  in_ch ();
  mh64a_out_if out_ch ();

  murmur_hash_64a DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_if       (in_ch),
    .out_if      (out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [31:0] seed_reg;
  mh_word_t    run_hash;
  mh_word_t    pending_hashes[$];
  mh_word_t    got_hash;
  int          error_count = 0;
  int          words_sent = 0;
  int          gap_next = 0;
  bit          gaps_on = 1'b1;
  int          hold_req = 0;

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    error_count++;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic mh_word_t mix_key_word(mh_word_t w);
    mh_word_t k;
    k = w * MH_MUL;
    k ^= k >> MH_SHIFT;
    k = k * MH_MUL;
    return k;
  endfunction

  // advance the running hash by one word, queue the finished hash on a last word
  function automatic void hash_step(key_word_t w);
    mh_word_t   h;
    mh_word_t   keep;
    logic [3:0] n;
    n = (w.nbytes > MH_FULL_BYTES) ? MH_FULL_BYTES : w.nbytes;
    h = w.first ? ({32'd0, seed_reg} ^ ({32'd0, w.len} * MH_MUL)) : run_hash;
    if (n == MH_FULL_BYTES) begin
      h ^= mix_key_word(w.data);
      h = h * MH_MUL;
    end else if (n != MH_NO_BYTES) begin
      keep = (64'd1 << (n * 8)) - 64'd1;
      h ^= w.data & keep;
      h = h * MH_MUL;
    end
    run_hash = h;
    if (w.last) begin
      h ^= h >> MH_SHIFT;
      h = h * MH_MUL;
      h ^= h >> MH_SHIFT;
      pending_hashes.push_back(h);
    end
  endfunction

  // valid is left high after a transaction when the next one follows without a gap
  task automatic send_word(key_word_t w);
    repeat (gap_next) @(posedge clk);
    in_ch.valid          <= 1'b1;
    in_ch.data_word      <= w.data;
    in_ch.valid_bytes    <= w.nbytes;
    in_ch.message_length <= w.len;
    in_ch.first_item     <= w.first;
    in_ch.last_item      <= w.last;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    hash_step(w);
    words_sent++;
    gap_next = pick_gap();
    if (gap_next > 0) in_ch.valid <= 1'b0;
  endtask

  task automatic send_key(int unsigned key_len, logic [31:0] msg_len);
    int unsigned words;
    int unsigned left;
    key_word_t   w;
    words = (key_len == 0) ? 1 : (key_len + 7) / 8;
    left  = key_len;
    for (int i = 0; i < words; i++) begin
      w.data   = {$urandom, $urandom};
      w.nbytes = (left >= 8) ? MH_FULL_BYTES : left[3:0];
      w.len    = (i == 0) ? msg_len : $urandom;
      w.first  = (i == 0);
      w.last   = (i == words - 1);
      left    -= (left >= 8) ? 8 : left;
      send_word(w);
    end
  endtask

  task automatic wait_idle();
    if (gap_next == 0) in_ch.valid <= 1'b0;
    if (gap_next == 0) gap_next = 1;
    while (pending_hashes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_seed(logic [31:0] v);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    seed_reg = v;
  endtask

  // receiver: random stalls, plus a long hold-off on request
  initial begin : sink_ready
    int hold_left;
    int stall_left;
    hold_left  = 0;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req <= 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_hashes.size() == 0) begin
        report_mismatch($sformatf("hash %h with none pending", out_ch.hash_value));
      end else begin
        got_hash = pending_hashes.pop_front();
        if (out_ch.hash_value !== got_hash)
          report_mismatch($sformatf("hash_value %h, want %h", out_ch.hash_value, got_hash));
      end
    end
  end

  task automatic test_no_first_after_reset();
    key_word_t w;
    // continue from the cleared hash without a first word
    w = '{data: {$urandom, $urandom}, nbytes: MH_FULL_BYTES, len: $urandom,
          first: 1'b0, last: 1'b1};
    send_word(w);
    // short word at the start of a key, followed by a full last word
    w = '{data: {$urandom, $urandom}, nbytes: 4'd3, len: 32'd11, first: 1'b1, last: 1'b0};
    send_word(w);
    w = '{data: {$urandom, $urandom}, nbytes: MH_FULL_BYTES, len: $urandom,
          first: 1'b0, last: 1'b1};
    send_word(w);
    // last word with no first since the previous result
    w = '{data: {$urandom, $urandom}, nbytes: MH_NO_BYTES, len: $urandom,
          first: 1'b0, last: 1'b1};
    send_word(w);
  endtask

  task automatic test_field_extremes();
    key_word_t w;
    for (int n = 0; n < 16; n++) begin
      w.data   = n[0] ? 64'hffff_ffff_ffff_ffff : 64'd0;
      w.nbytes = n[3:0];
      w.len    = n[1] ? 32'hffff_ffff : 32'd0;
      w.first  = 1'b1;
      w.last   = 1'b1;
      send_word(w);
    end
    send_key(0, 32'd0);
    send_key(8, 32'd8);
  endtask

  task automatic test_seed_settings();
    logic [31:0] seeds[4];
    seeds = '{32'd0, 32'hffff_ffff, $urandom, MH_SEED_RST};
    send_key($urandom_range(0, 20), 32'd5);
    foreach (seeds[i]) begin
      write_seed(seeds[i]);
      for (int k = 0; k < 5; k++) send_key($urandom_range(0, 24), $urandom);
    end
  endtask

  task automatic test_backpressure();
    wait_idle();
    gaps_on = 1'b0;
    hold_req <= 300;
    for (int k = 0; k < 30; k++) send_key($urandom_range(1, 8), $urandom_range(0, 8));
    gaps_on = 1'b1;
  endtask

  task automatic test_random_keys();
    int          start_cnt;
    int unsigned key_len;
    key_word_t   w;
    for (int phase = 0; phase < 4; phase++) begin
      write_seed($urandom);
      gaps_on   = (phase != 2);
      start_cnt = words_sent;
      while (words_sent - start_cnt < RANDOM_WORDS / 4) begin
        if ($urandom_range(0, 99) < 85) begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: key_len = $urandom_range(0, 24);
            6, 7, 8:          key_len = $urandom_range(25, 80);
            default:          key_len = $urandom_range(81, 300);
          endcase
          send_key(key_len, ($urandom_range(0, 9) == 0) ? $urandom : key_len);
        end else begin
          w.data   = {$urandom, $urandom};
          w.nbytes = 4'($urandom_range(0, 15));
          w.len    = $urandom;
          w.first  = 1'($urandom_range(0, 1));
          w.last   = 1'($urandom_range(0, 1));
          send_word(w);
        end
      end
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    rst_n                <= 1'b0;
    cfg_wr_en            <= 1'b0;
    cfg_wr_data          <= 32'd0;
    in_ch.valid          <= 1'b0;
    in_ch.data_word      <= 64'd0;
    in_ch.valid_bytes    <= MH_NO_BYTES;
    in_ch.message_length <= 32'd0;
    in_ch.first_item     <= 1'b0;
    in_ch.last_item      <= 1'b0;
    seed_reg = MH_SEED_RST;
    run_hash = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_no_first_after_reset();
    test_field_extremes();
    test_seed_settings();
    test_backpressure();
    test_random_keys();

    wait_idle();
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #(LIMIT_NS);
    $display("[%0t] timeout, %0d hashes pending", $time, pending_hashes.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
